@@ design/fali_pkg.sv @@
// fali_pkg: shared types and constants for the four axis linear interpolator
// item structs, lane control struct, limit register reset values
// no dependencies
package fali_pkg;

	localparam int NUM_JOINTS_DEF = 4;
	localparam int NUM_TARGETS    = 4;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_W      = 3;
	localparam int ANGLE_W        = 8;

	localparam logic [ANGLE_W-1:0] RESET_POSITION = 8'd100;

	localparam logic [ANGLE_W-1:0] REG_RESET [NUM_REGS] = '{
		8'd0, 8'd180, 8'd85, 8'd180, 8'd80, 8'd180, 8'd120, 8'd175
	};

	typedef enum logic {
		CMD_MOVE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               cmd;
		logic [ANGLE_W-1:0] target_pan;
		logic [ANGLE_W-1:0] target_shoulder;
		logic [ANGLE_W-1:0] target_elbow;
		logic [ANGLE_W-1:0] target_gripper;
	} req_item_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] pan_angle;
		logic [ANGLE_W-1:0] shoulder_angle;
		logic [ANGLE_W-1:0] elbow_angle;
		logic [ANGLE_W-1:0] gripper_angle;
		logic               driven;
		logic               moving;
	} rsp_item_t;

	typedef struct packed {
		logic               load;
		logic               tick;
		logic [ANGLE_W-1:0] run;
	} lane_ctl_t;

endpackage

@@ design/four_axis_linear_interpolator.sv @@
// four_axis_linear_interpolator: coordinated linear move of up to four joints
// depends on fali_pkg, fali_lane, fali_merge
// result: registered on the clock edge that accepts the item
// throughput: one item per cycle while results are taken, set by the single-step quotient and remainder update per lane
// a new item is taken while a result waits only if that result is taken in the same cycle
// reset: positions 100, idle, limit registers to their defaults, output empty
module four_axis_linear_interpolator #(
	parameter int NUM_JOINTS = fali_pkg::NUM_JOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  fali_pkg::req_item_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output fali_pkg::rsp_item_t            rsp,
	input  logic                           cfg_we,
	input  logic [fali_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [fali_pkg::ANGLE_W-1:0]   cfg_data
);

	logic [7:0] regs_q [fali_pkg::NUM_REGS];
	logic [7:0] run_q;
	logic [7:0] step_q;
	logic       rsp_valid_q;
	fali_pkg::rsp_item_t rsp_q;

	logic       accept;
	logic       load;
	logic       tick;
	logic [7:0] longest;
	logic [8:0] step_inc;
	logic [7:0] step_nxt;
	logic [7:0] run_nxt;
	fali_pkg::lane_ctl_t lane_ctl;
	fali_pkg::rsp_item_t rsp_nxt;

	logic [7:0] targets [fali_pkg::NUM_TARGETS];
	logic [7:0] pos_nxt [NUM_JOINTS];
	logic [7:0] mags    [NUM_JOINTS];
	logic [7:0] angles  [fali_pkg::NUM_TARGETS];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign load      = accept && (req.cmd == fali_pkg::CMD_MOVE);
	assign tick      = accept && (req.cmd == fali_pkg::CMD_TICK) && (step_q != '0);

	assign targets[0] = req.target_pan;
	assign targets[1] = req.target_shoulder;
	assign targets[2] = req.target_elbow;
	assign targets[3] = req.target_gripper;

	assign lane_ctl.load = load;
	assign lane_ctl.tick = tick;
	assign lane_ctl.run  = run_q;

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
		if (j < fali_pkg::NUM_TARGETS) begin : g_tgt
			fali_lane #(.HAS_TARGET(1'b1)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (lane_ctl),
				.target  (targets[j]),
				.lo      (regs_q[2*j]),
				.hi      (regs_q[2*j+1]),
				.pos_nxt (pos_nxt[j]),
				.mag     (mags[j])
			);
		end else begin : g_hold
			fali_lane #(.HAS_TARGET(1'b0)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (lane_ctl),
				.target  (8'd0),
				.lo      (8'd0),
				.hi      (8'd0),
				.pos_nxt (pos_nxt[j]),
				.mag     (mags[j])
			);
		end
	end

	fali_merge #(.NUM_JOINTS(NUM_JOINTS)) u_merge (
		.mags    (mags),
		.longest (longest)
	);

	for (genvar j = 0; j < fali_pkg::NUM_TARGETS; j++) begin : g_ang
		if (j < NUM_JOINTS) begin : g_on
			assign angles[j] = pos_nxt[j];
		end else begin : g_off
			assign angles[j] = '0;
		end
	end

	always_comb begin
		step_inc = {1'b0, step_q} + 9'd1;
		run_nxt  = run_q;
		step_nxt = step_q;
		if (load) begin
			run_nxt  = longest;
			step_nxt = (longest != '0) ? 8'd1 : 8'd0;
		end else if (tick) begin
			step_nxt = (step_inc > {1'b0, run_q}) ? 8'd0 : step_inc[7:0];
		end
		rsp_nxt.pan_angle      = angles[0];
		rsp_nxt.shoulder_angle = angles[1];
		rsp_nxt.elbow_angle    = angles[2];
		rsp_nxt.gripper_angle  = angles[3];
		rsp_nxt.driven         = tick;
		rsp_nxt.moving         = (step_nxt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fali_pkg::NUM_REGS; i++) begin
				regs_q[i] <= fali_pkg::REG_RESET[i];
			end
			run_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				regs_q[cfg_idx] <= cfg_data;
			end
			run_q  <= run_nxt;
			step_q <= step_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/fali_lane.sv @@
// fali_lane: one joint of the interpolator
// clamps the target (a hold lane keeps its place), latches start and delta,
// tracks floor(step*delta/run) by running quotient and remainder; needs fali_pkg
module fali_lane #(
	parameter bit HAS_TARGET = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fali_pkg::lane_ctl_t          ctl,
	input  logic [fali_pkg::ANGLE_W-1:0] target,
	input  logic [fali_pkg::ANGLE_W-1:0] lo,
	input  logic [fali_pkg::ANGLE_W-1:0] hi,
	output logic [fali_pkg::ANGLE_W-1:0] pos_nxt,
	output logic [fali_pkg::ANGLE_W-1:0] mag
);

	logic [7:0]        pos_q;
	logic [7:0]        start_q;
	logic signed [8:0] delta_q;
	logic signed [9:0] quot_q;
	logic [7:0]        rem_q;

	logic [7:0]         lim_lo;
	logic [7:0]         end_pos;
	logic signed [8:0]  d;
	logic [8:0]         d_abs;
	logic signed [10:0] acc;
	logic signed [10:0] run_s;
	logic signed [10:0] rem_n;
	logic signed [9:0]  quot_n;

	always_comb begin
		lim_lo = (target < lo) ? lo : target;
		if (HAS_TARGET) begin
			end_pos = (lim_lo > hi) ? hi : lim_lo;
		end else begin
			end_pos = pos_q;
		end
		d     = signed'({1'b0, end_pos}) - signed'({1'b0, pos_q});
		d_abs = d[8] ? 9'(-d) : 9'(d);
		mag   = d_abs[7:0];

		run_s = signed'({3'b000, ctl.run});
		acc   = signed'({3'b000, rem_q}) + 11'(delta_q);
		if (acc >= run_s) begin
			rem_n  = acc - run_s;
			quot_n = quot_q + 10'sd1;
		end else if (acc < 11'sd0) begin
			rem_n  = acc + run_s;
			quot_n = quot_q - 10'sd1;
		end else begin
			rem_n  = acc;
			quot_n = quot_q;
		end
		pos_nxt = ctl.tick ? (start_q + quot_n[7:0]) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= fali_pkg::RESET_POSITION;
			start_q <= '0;
			delta_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (ctl.load) begin
			start_q <= pos_q;
			delta_q <= d;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (ctl.tick) begin
			pos_q  <= pos_nxt;
			quot_q <= quot_n;
			rem_q  <= rem_n[7:0];
		end
	end

endmodule

@@ design/fali_merge.sv @@
// fali_merge: combines the lanes' absolute deltas into the run length
// largest magnitude over all joints; depends on fali_pkg
module fali_merge #(
	parameter int NUM_JOINTS = fali_pkg::NUM_JOINTS_DEF
) (
	input  logic [fali_pkg::ANGLE_W-1:0] mags [NUM_JOINTS],
	output logic [fali_pkg::ANGLE_W-1:0] longest
);

	always_comb begin
		longest = '0;
		for (int j = 0; j < NUM_JOINTS; j++) begin
			if (mags[j] > longest) begin
				longest = mags[j];
			end
		end
	end

endmodule

@@ test/tb_four_axis_linear_interpolator.sv @@
// tb_four_axis_linear_interpolator: self-checking bench for the four axis linear interpolator
// drives move and tick items under several limit settings and idle patterns, checks every result
// depends on fali_pkg and four_axis_linear_interpolator
module tb_four_axis_linear_interpolator;

	localparam int NUM_TARGETS = fali_pkg::NUM_TARGETS;
	localparam int NUM_REGS    = fali_pkg::NUM_REGS;
	localparam int REG_IDX_W   = fali_pkg::REG_IDX_W;
	localparam int ANGLE_W     = fali_pkg::ANGLE_W;

	localparam int REG_PAN_MIN      = 0;
	localparam int REG_PAN_MAX      = 1;
	localparam int REG_SHOULDER_MIN = 2;
	localparam int REG_SHOULDER_MAX = 3;
	localparam int REG_ELBOW_MIN    = 4;
	localparam int REG_ELBOW_MAX    = 5;
	localparam int REG_GRIPPER_MIN  = 6;
	localparam int REG_GRIPPER_MAX  = 7;

	localparam int MIN_REG [NUM_TARGETS] = '{
		REG_PAN_MIN, REG_SHOULDER_MIN, REG_ELBOW_MIN, REG_GRIPPER_MIN
	};
	localparam int MAX_REG [NUM_TARGETS] = '{
		REG_PAN_MAX, REG_SHOULDER_MAX, REG_ELBOW_MAX, REG_GRIPPER_MAX
	};

	localparam int NUM_PHASES  = 6;
	localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 150, 150, 50, 150, 200};
	localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 77, 0, 16, 0, 16};
	localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 77, 16, 0, 16};

	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS  = 10;

	typedef logic [NUM_REGS-1:0][ANGLE_W-1:0] limit_regs_t;

	typedef struct packed {
		logic [NUM_TARGETS-1:0][ANGLE_W-1:0] pos;
		logic [NUM_TARGETS-1:0][ANGLE_W-1:0] start;
		logic [NUM_TARGETS-1:0][8:0]         delta;
		logic [ANGLE_W-1:0]                  run;
		logic [8:0]                          step;
	} joint_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	fali_pkg::req_item_t  req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	fali_pkg::rsp_item_t  rsp;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_idx = '0;
	logic [ANGLE_W-1:0]   cfg_data = '0;

	fali_pkg::req_item_t pending_cmds [$];
	fali_pkg::rsp_item_t expected_angles [$];
	joint_state_t gen_state;
	joint_state_t mon_state;
	limit_regs_t  gen_limits;
	limit_regs_t  mon_limits;

	int  sender_idle_pct = 0;
	int  receiver_stall_pct = 0;
	int  hold_requests = 0;
	int  holds_served = 0;
	int  hold_left = 0;
	bit  req_fire = 1'b0;
	int  items_made = 0;
	int  mismatch_count = 0;
	int  results_checked = 0;
	int  driven_steps = 0;
	int  moves_seen = 0;
	int  limit_settings = 0;
	int  cycle_count = 0;

	four_axis_linear_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic joint_state_t fresh_joints();
		joint_state_t s;
		int j;
		s = '0;
		for (j = 0; j < NUM_TARGETS; j++) begin
			s.pos[j] = fali_pkg::RESET_POSITION;
		end
		return s;
	endfunction

	function automatic fali_pkg::rsp_item_t step_joints(inout joint_state_t s,
			input limit_regs_t lim, input fali_pkg::req_item_t it);
		fali_pkg::rsp_item_t r;
		logic [NUM_TARGETS-1:0][ANGLE_W-1:0] tgt;
		int j, v, d, longest, num, q;
		r = '0;
		tgt[0] = it.target_pan;
		tgt[1] = it.target_shoulder;
		tgt[2] = it.target_elbow;
		tgt[3] = it.target_gripper;
		if (it.cmd == fali_pkg::CMD_MOVE) begin
			longest = 0;
			for (j = 0; j < NUM_TARGETS; j++) begin
				v = int'(tgt[j]);
				if (v < int'(lim[MIN_REG[j]])) v = int'(lim[MIN_REG[j]]);
				if (v > int'(lim[MAX_REG[j]])) v = int'(lim[MAX_REG[j]]);
				s.start[j] = s.pos[j];
				d = v - int'(s.pos[j]);
				s.delta[j] = d[8:0];
				if (d < 0) d = -d;
				if (d > longest) longest = d;
			end
			s.run = longest[ANGLE_W-1:0];
			s.step = (s.run != '0) ? 9'd1 : 9'd0;
		end else if (s.step != '0) begin
			for (j = 0; j < NUM_TARGETS; j++) begin
				num = int'(s.step) * int'($signed(s.delta[j]));
				q = num / int'(s.run);
				// round toward minus infinity on a downward move
				if ((num % int'(s.run)) != 0 && num < 0) q = q - 1;
				v = int'(s.start[j]) + q;
				s.pos[j] = v[ANGLE_W-1:0];
			end
			r.driven = 1'b1;
			s.step = s.step + 9'd1;
			if (s.step > {1'b0, s.run}) s.step = '0;
		end
		r.pan_angle      = s.pos[0];
		r.shoulder_angle = s.pos[1];
		r.elbow_angle    = s.pos[2];
		r.gripper_angle  = s.pos[3];
		r.moving         = (s.step != '0);
		return r;
	endfunction

	function automatic fali_pkg::req_item_t random_item();
		fali_pkg::req_item_t it;
		it.cmd             = 1'($urandom_range(1, 0));
		it.target_pan      = ANGLE_W'($urandom_range(255, 0));
		it.target_shoulder = ANGLE_W'($urandom_range(255, 0));
		it.target_elbow    = ANGLE_W'($urandom_range(255, 0));
		it.target_gripper  = ANGLE_W'($urandom_range(255, 0));
		return it;
	endfunction

	task automatic queue_item(input fali_pkg::req_item_t it);
		void'(step_joints(gen_state, gen_limits, it));
		pending_cmds.push_back(it);
		items_made++;
	endtask

	task automatic queue_tick();
		fali_pkg::req_item_t it;
		it = random_item();
		it.cmd = fali_pkg::CMD_TICK;
		queue_item(it);
	endtask

	task automatic queue_move(input logic [ANGLE_W-1:0] p, input logic [ANGLE_W-1:0] s,
			input logic [ANGLE_W-1:0] e, input logic [ANGLE_W-1:0] g);
		fali_pkg::req_item_t it;
		it.cmd             = fali_pkg::CMD_MOVE;
		it.target_pan      = p;
		it.target_shoulder = s;
		it.target_elbow    = e;
		it.target_gripper  = g;
		queue_item(it);
	endtask

	task automatic queue_random(input int n);
		logic [NUM_TARGETS-1:0][ANGLE_W-1:0] tg;
		int goal, j, t;
		bit wide;
		goal = items_made + n;
		while (items_made < goal) begin
			if ($urandom_range(99, 0) < 10) begin
				queue_item(random_item());
			end else begin
				wide = ($urandom_range(99, 0) < 30);
				for (j = 0; j < NUM_TARGETS; j++) begin
					if (wide) begin
						t = $urandom_range(255, 0);
					end else begin
						// short hop around the current angle keeps runs short
						t = int'(gen_state.pos[j]) + int'($urandom_range(16, 0)) - 8;
						if (t < 0) t = 0;
						if (t > 255) t = 255;
					end
					tg[j] = t[ANGLE_W-1:0];
				end
				queue_move(tg[0], tg[1], tg[2], tg[3]);
				if ($urandom_range(99, 0) < 80) begin
					while (gen_state.step != '0 && items_made < goal) queue_tick();
				end else begin
					repeat ($urandom_range(6, 0)) queue_tick();
				end
			end
		end
	endtask

	task automatic write_reg(input int idx, input logic [ANGLE_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_IDX_W'(idx);
		cfg_data <= val;
		gen_limits[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_joint_limits(input int j, input logic [ANGLE_W-1:0] lo,
			input logic [ANGLE_W-1:0] hi);
		write_reg(MIN_REG[j], lo);
		write_reg(MAX_REG[j], hi);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || req_valid || expected_angles.size() > 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
					req       <= pending_cmds.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left    <= HOLD_CYCLES;
			rsp_ready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		fali_pkg::rsp_item_t want;
		if (arst_n) begin
			if (cfg_we) mon_limits[cfg_idx] = cfg_data;
			if (rsp_valid && rsp_ready) begin
				if (expected_angles.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result at cycle %0d: %p", cycle_count, rsp);
				end else begin
					want = expected_angles.pop_front();
					results_checked++;
					if (rsp.pan_angle !== want.pan_angle
							|| rsp.shoulder_angle !== want.shoulder_angle
							|| rsp.elbow_angle !== want.elbow_angle
							|| rsp.gripper_angle !== want.gripper_angle
							|| rsp.driven !== want.driven
							|| rsp.moving !== want.moving) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("mismatch on result %0d: expected %p, got %p",
								results_checked, want, rsp);
					end
				end
			end
			req_fire = req_valid && req_ready;
			if (req_fire) begin
				if (req.cmd == fali_pkg::CMD_MOVE) moves_seen++;
				want = step_joints(mon_state, mon_limits, req);
				if (want.driven) driven_steps++;
				expected_angles.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycle_count, expected_angles.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int i, ph, j;
		for (i = 0; i < NUM_REGS; i++) begin
			gen_limits[i] = fali_pkg::REG_RESET[i];
			mon_limits[i] = fali_pkg::REG_RESET[i];
		end
		gen_state = fresh_joints();
		mon_state = fresh_joints();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits: clamping at both ends, restart mid move, zero length move
		queue_tick();
		queue_move(8'd0, 8'd0, 8'd0, 8'd0);
		repeat (3) queue_tick();
		queue_move(8'd255, 8'd255, 8'd255, 8'd255);
		repeat (2) queue_tick();
		queue_move(gen_state.pos[0], gen_state.pos[1], gen_state.pos[2], gen_state.pos[3]);
		queue_tick();
		queue_move(gen_state.pos[0] + 8'd1, gen_state.pos[1], gen_state.pos[2],
			gen_state.pos[3]);
		repeat (2) queue_tick();
		queue_move(8'h55, 8'hAA, 8'h55, 8'hAA);
		repeat (4) queue_tick();
		wait_drained();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			for (j = 0; j < NUM_TARGETS; j++) begin
				case (ph)
					0: set_joint_limits(j, 8'd0, 8'd255);
					1: set_joint_limits(j, ANGLE_W'($urandom_range(255, 0)),
						ANGLE_W'($urandom_range(255, 0)));
					2: begin
						i = $urandom_range(180, 0);
						set_joint_limits(j, i[ANGLE_W-1:0],
							ANGLE_W'($urandom_range(180, i)));
					end
					3: begin
						// pinned and crossed limits
						if (j == 0) set_joint_limits(j, 8'd0, 8'd0);
						else if (j == 1) set_joint_limits(j, 8'd255, 8'd255);
						else if (j == 2) set_joint_limits(j, 8'd180, 8'd0);
						else set_joint_limits(j, 8'd255, 8'd0);
					end
					4: set_joint_limits(j, fali_pkg::REG_RESET[MIN_REG[j]],
						fali_pkg::REG_RESET[MAX_REG[j]]);
					default: set_joint_limits(j, ANGLE_W'($urandom_range(255, 0)),
						ANGLE_W'($urandom_range(255, 0)));
				endcase
			end
			limit_settings++;
			sender_idle_pct    = PHASE_IDLE[ph];
			receiver_stall_pct = PHASE_STALL[ph];
			// long receiver hold while the sender keeps offering items
			if (ph == 0) hold_requests++;
			queue_random(PHASE_ITEMS[ph]);
			wait_drained();
		end

		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_angles.size() != 0)
			$display("%0d expected results never arrived", expected_angles.size());
		$display("checked %0d results: %0d moves, %0d interpolation steps, %0d limit settings",
			results_checked, moves_seen, driven_steps, limit_settings + 1);
		$display("mismatches: %0d", mismatch_count);
		if (mismatch_count == 0 && expected_angles.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/fali_pkg.sv
design/fali_lane.sv
design/fali_merge.sv
design/four_axis_linear_interpolator.sv
test/tb_four_axis_linear_interpolator.sv
